FILE: rtl/h2d_pkg.sv
package h2d_pkg;

    localparam int unsigned LEN_W    = 24;
    localparam int unsigned STREAM_W = 31;

    localparam logic [4:0]       PREFACE_LAST     = 5'd23;
    localparam logic [3:0]       HEADER_LAST      = 4'd8;
    localparam logic [LEN_W-1:0] MAX_FRAME_RESET  = 24'd16384;
    localparam logic [7:0]       TYPE_HEADERS     = 8'h01;
    localparam logic [7:0]       TYPE_SETTINGS    = 8'h04;
    localparam int unsigned      FLAG_ACK_BIT     = 0;
    localparam int unsigned      FLAG_PADDED_BIT  = 3;
    localparam int unsigned      FLAG_PRIO_BIT    = 5;
    localparam logic [LEN_W-1:0] PRIO_LEN         = 24'd5;
    localparam logic [LEN_W-1:0] PAD_START        = 24'd1;
    localparam logic [LEN_W-1:0] PAD_PRIO_START   = 24'd6;

    typedef enum logic [1:0] {
        PH_PREFACE,
        PH_HEADER,
        PH_PAYLOAD,
        PH_DEAD
    } t_phase;

    typedef enum logic [2:0] {
        KIND_BLOCK_BYTE    = 3'd0,
        KIND_EMPTY_BLOCK   = 3'd1,
        KIND_SEND_SETTINGS = 3'd2,
        KIND_SEND_ACK      = 3'd3,
        KIND_BAD_PREFACE   = 3'd4,
        KIND_TOO_LARGE     = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [7:0]           data;
        logic [STREAM_W-1:0]  stream_no;
        logic                 last;
    } t_result;

    // client connection preface, one byte per position
    function automatic logic [7:0] preface_byte(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h50;
            5'd1:    c = 8'h52;
            5'd2:    c = 8'h49;
            5'd3:    c = 8'h20;
            5'd4:    c = 8'h2a;
            5'd5:    c = 8'h20;
            5'd6:    c = 8'h48;
            5'd7:    c = 8'h54;
            5'd8:    c = 8'h54;
            5'd9:    c = 8'h50;
            5'd10:   c = 8'h2f;
            5'd11:   c = 8'h32;
            5'd12:   c = 8'h2e;
            5'd13:   c = 8'h30;
            5'd14:   c = 8'h0d;
            5'd15:   c = 8'h0a;
            5'd16:   c = 8'h0d;
            5'd17:   c = 8'h0a;
            5'd18:   c = 8'h53;
            5'd19:   c = 8'h4d;
            5'd20:   c = 8'h0d;
            5'd21:   c = 8'h0a;
            5'd22:   c = 8'h0d;
            5'd23:   c = 8'h0a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/h2d_if.sv
interface h2d_in_if import h2d_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface h2d_out_if import h2d_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          kind;
    logic [7:0]          data;
    logic [STREAM_W-1:0] stream_no;
    logic                last;

    modport source (output valid, output kind, output data, output stream_no, output last,
                    input ready);
    modport sink   (input valid, input kind, input data, input stream_no, input last,
                    output ready);
endinterface

interface h2d_cfg_if import h2d_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] max_frame_size;

    modport source (output valid, output max_frame_size, input ready);
    modport sink   (input valid, input max_frame_size, output ready);
endinterface

FILE: rtl/http2_frame_deframer.sv
// a result beat is registered and valid on the cycle after the byte beat that causes it
// throughput: one byte per cycle while the output register is not stalled; the state update is a single pass per byte
// the output register takes a new result whenever it is empty or being drained
// configuration writes are taken every cycle (ready held high)
// synchronous active-low reset: preface phase, counters cleared, max frame size 16384
module http2_frame_deframer import h2d_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    h2d_in_if.sink     i_in,
    h2d_cfg_if.sink    i_cfg,
    h2d_out_if.source  o_out
);

    logic    accept;
    logic    res_valid;
    t_result res;

    assign i_in.ready  = !o_out.valid || o_out.ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_in.valid && i_in.ready;

    h2d_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_in.in_byte),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_max   (i_cfg.max_frame_size),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    h2d_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && res_valid),
        .i_res   (res),
        .o_out   (o_out)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("byte taken while result stalled");

    a_data_only_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.kind != KIND_BLOCK_BYTE) |-> o_out.data == 8'h0)
        else $error("data set on non-byte result");

    a_no_stream_preface: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && ((o_out.kind == KIND_SEND_SETTINGS) || (o_out.kind == KIND_BAD_PREFACE))
        |-> o_out.stream_no == '0)
        else $error("stream id on connection-level result");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last
        |-> (o_out.kind == KIND_BLOCK_BYTE) || (o_out.kind == KIND_EMPTY_BLOCK))
        else $error("last on non-block result");

endmodule

FILE: rtl/h2d_parser.sv
module h2d_parser import h2d_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_max,
    output logic             o_res_valid,
    output t_result          o_res
);

    t_phase              r_phase, n_phase;
    logic [4:0]          r_pcount, n_pcount;
    logic                r_match, n_match;
    logic [3:0]          r_hcount, n_hcount;
    logic [LEN_W-1:0]    r_len, n_len;
    logic [7:0]          r_type, n_type;
    logic [7:0]          r_flags, n_flags;
    logic [STREAM_W-1:0] r_stream, n_stream;
    logic [LEN_W-1:0]    r_plcount, n_plcount;
    logic [LEN_W-1:0]    r_start, n_start;
    logic [LEN_W-1:0]    r_end, n_end;
    logic [LEN_W-1:0]    r_max;

    logic [STREAM_W-1:0] hdr_stream;
    logic [LEN_W-1:0]    byte_ext;
    logic [LEN_W-1:0]    pl_inc;
    logic [LEN_W-1:0]    pad_end;
    logic                blk_hdr;
    logic                blk_pl;
    logic                done;
    logic                done_blk;

    assign hdr_stream = {r_stream[STREAM_W-1:8], i_byte};
    assign byte_ext   = {16'h0, i_byte};
    assign pl_inc     = r_plcount + 24'd1;
    assign blk_hdr    = (r_type == TYPE_HEADERS) && (hdr_stream != '0);
    assign blk_pl     = (r_type == TYPE_HEADERS) && (r_stream != '0);
    // pad length that does not fit leaves the block end alone
    assign pad_end    = (byte_ext < r_len) ? (r_len - byte_ext) : r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_PREFACE;
            r_pcount  <= '0;
            r_match   <= 1'b1;
            r_hcount  <= '0;
            r_len     <= '0;
            r_type    <= '0;
            r_flags   <= '0;
            r_stream  <= '0;
            r_plcount <= '0;
            r_start   <= '0;
            r_end     <= '0;
            r_max     <= MAX_FRAME_RESET;
        end else begin
            r_phase   <= n_phase;
            r_pcount  <= n_pcount;
            r_match   <= n_match;
            r_hcount  <= n_hcount;
            r_len     <= n_len;
            r_type    <= n_type;
            r_flags   <= n_flags;
            r_stream  <= n_stream;
            r_plcount <= n_plcount;
            r_start   <= n_start;
            r_end     <= n_end;
            if (i_cfg_we) begin
                r_max <= i_cfg_max;
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pcount    = r_pcount;
        n_match     = r_match;
        n_hcount    = r_hcount;
        n_len       = r_len;
        n_type      = r_type;
        n_flags     = r_flags;
        n_stream    = r_stream;
        n_plcount   = r_plcount;
        n_start     = r_start;
        n_end       = r_end;
        done        = 1'b0;
        done_blk    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_BLOCK_BYTE, data: 8'h0, stream_no: '0, last: 1'b0};

        if (i_accept) begin
            case (r_phase)
                PH_PREFACE: begin
                    n_match  = r_match && (i_byte == preface_byte(r_pcount));
                    n_pcount = r_pcount + 5'd1;
                    if (r_pcount == PREFACE_LAST) begin
                        o_res_valid = 1'b1;
                        if (n_match) begin
                            n_phase    = PH_HEADER;
                            n_hcount   = '0;
                            o_res.kind = KIND_SEND_SETTINGS;
                        end else begin
                            n_phase    = PH_DEAD;
                            o_res.kind = KIND_BAD_PREFACE;
                        end
                    end
                end
                PH_HEADER: begin
                    case (r_hcount)
                        4'd0:    n_len = {i_byte, 16'h0};
                        4'd1:    n_len[15:8] = i_byte;
                        4'd2:    n_len[7:0] = i_byte;
                        4'd3:    n_type = i_byte;
                        4'd4:    n_flags = i_byte;
                        4'd5:    n_stream = {i_byte[6:0], 24'h0};
                        4'd6:    n_stream[23:16] = i_byte;
                        4'd7:    n_stream[15:8] = i_byte;
                        default: n_stream = hdr_stream;
                    endcase
                    if (r_hcount == HEADER_LAST) begin
                        n_hcount = '0;
                        if (r_len > r_max) begin
                            n_phase           = PH_DEAD;
                            o_res_valid       = 1'b1;
                            o_res.kind        = KIND_TOO_LARGE;
                            o_res.stream_no   = hdr_stream;
                        end else begin
                            n_start = '0;
                            n_end   = '0;
                            if (blk_hdr) begin
                                n_end = r_len;
                                if (r_flags[FLAG_PADDED_BIT] && (r_len != '0)) begin
                                    n_start = PAD_START;
                                end else if (r_flags[FLAG_PRIO_BIT] && (r_len >= PRIO_LEN)) begin
                                    n_start = PRIO_LEN;
                                end
                            end
                            if (r_len == '0) begin
                                done     = 1'b1;
                                done_blk = blk_hdr;
                            end else begin
                                n_phase   = PH_PAYLOAD;
                                n_plcount = '0;
                            end
                        end
                    end else begin
                        n_hcount = r_hcount + 4'd1;
                    end
                end
                PH_PAYLOAD: begin
                    if (blk_pl) begin
                        if ((r_plcount == '0) && r_flags[FLAG_PADDED_BIT]) begin
                            // pad length byte: never part of the block
                            n_end = pad_end;
                            if (r_flags[FLAG_PRIO_BIT] && (pad_end >= PAD_PRIO_START)) begin
                                n_start = PAD_PRIO_START;
                            end
                        end else if ((r_plcount >= r_start) && (r_plcount < r_end)) begin
                            o_res_valid     = 1'b1;
                            o_res.kind      = KIND_BLOCK_BYTE;
                            o_res.data      = i_byte;
                            o_res.stream_no = r_stream;
                            o_res.last      = (pl_inc == r_end);
                        end
                    end
                    n_plcount = pl_inc;
                    if (pl_inc == r_len) begin
                        n_phase  = PH_HEADER;
                        n_hcount = '0;
                        done     = 1'b1;
                        done_blk = blk_pl;
                    end
                end
                default: begin
                end
            endcase

            // end of frame report when no block byte went out
            if (done && !o_res_valid) begin
                if ((r_type == TYPE_SETTINGS) && !r_flags[FLAG_ACK_BIT]) begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_SEND_ACK;
                    o_res.stream_no = n_stream;
                end else if (done_blk && (n_start == n_end)) begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = KIND_EMPTY_BLOCK;
                    o_res.stream_no = n_stream;
                    o_res.last      = 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/h2d_out_reg.sv
module h2d_out_reg import h2d_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_res,
    h2d_out_if.source o_out
);

    logic    r_valid;
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.kind      = r_res.kind;
    assign o_out.data      = r_res.data;
    assign o_out.stream_no = r_res.stream_no;
    assign o_out.last      = r_res.last;

endmodule

FILE: verif/h2d_deframe_checker.sv
module h2d_deframe_checker import h2d_pkg::*; #(
    parameter logic [8*24-1:0] PREFACE = '0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    h2d_in_if    conn_ch,
    h2d_cfg_if   cfg_ch,
    h2d_out_if   res_ch,
    output int   o_errors,
    output int   o_pending
);

    // own copy of the deframer state
    t_phase              stage;
    int unsigned         pre_idx;
    bit                  pre_ok;
    int unsigned         hdr_idx;
    logic [LEN_W-1:0]    flen;
    logic [7:0]          ftype;
    logic [7:0]          fflags;
    logic [STREAM_W-1:0] fstream;
    logic [LEN_W-1:0]    pay_idx;
    logic [LEN_W-1:0]    blk_lo;
    logic [LEN_W-1:0]    blk_hi;
    logic [LEN_W-1:0]    max_len;

    t_result expected_results[$];
    t_result want;
    t_result predicted;

    function automatic bit carries_block();
        return ftype == TYPE_HEADERS && fstream != '0;
    endfunction

    function automatic void drop_priority();
        if (fflags[FLAG_PRIO_BIT] && blk_hi - blk_lo >= 5)
            blk_lo = blk_lo + 5;
    endfunction

    // result of a frame whose final byte has just been taken
    function automatic bit frame_end(output t_result r);
        r = '0;
        if (ftype == TYPE_SETTINGS && !fflags[FLAG_ACK_BIT]) begin
            r.kind      = KIND_SEND_ACK;
            r.stream_no = fstream;
            return 1'b1;
        end
        if (carries_block() && blk_lo == blk_hi) begin
            r.kind      = KIND_EMPTY_BLOCK;
            r.stream_no = fstream;
            r.last      = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output t_result r);
        bit               hit;
        logic [LEN_W-1:0] p;
        hit = 1'b0;
        r   = '0;
        case (stage)
            PH_PREFACE: begin
                if (b != PREFACE[8*(23-pre_idx) +: 8])
                    pre_ok = 1'b0;
                pre_idx++;
                if (pre_idx == 24) begin
                    hit     = 1'b1;
                    r.kind  = pre_ok ? KIND_SEND_SETTINGS : KIND_BAD_PREFACE;
                    stage   = pre_ok ? PH_HEADER : PH_DEAD;
                    hdr_idx = 0;
                end
            end
            PH_HEADER: begin
                case (hdr_idx)
                    0:       flen = {b, 16'h0000};
                    1:       flen[15:8] = b;
                    2:       flen[7:0] = b;
                    3:       ftype = b;
                    4:       fflags = b;
                    5:       fstream = {b[6:0], 24'h000000};
                    6:       fstream[23:16] = b;
                    7:       fstream[15:8] = b;
                    default: fstream[7:0] = b;
                endcase
                hdr_idx++;
                if (hdr_idx == 9) begin
                    hdr_idx = 0;
                    if (flen > max_len) begin
                        stage       = PH_DEAD;
                        hit         = 1'b1;
                        r.kind      = KIND_TOO_LARGE;
                        r.stream_no = fstream;
                    end else begin
                        blk_lo = '0;
                        blk_hi = '0;
                        if (carries_block()) begin
                            blk_hi = flen;
                            // pad length byte decides the range once it arrives
                            if (fflags[FLAG_PADDED_BIT] && flen != '0)
                                blk_lo = 1;
                            else
                                drop_priority();
                        end
                        if (flen == '0) begin
                            hit = frame_end(r);
                        end else begin
                            stage   = PH_PAYLOAD;
                            pay_idx = '0;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                p = pay_idx;
                if (carries_block()) begin
                    if (p == '0 && fflags[FLAG_PADDED_BIT]) begin
                        // oversized padding is kept as block bytes
                        if (b <= flen - 1)
                            blk_hi = flen - b;
                        drop_priority();
                    end
                    if (p >= blk_lo && p < blk_hi) begin
                        hit         = 1'b1;
                        r.kind      = KIND_BLOCK_BYTE;
                        r.data      = b;
                        r.stream_no = fstream;
                        r.last      = (p + 1 == blk_hi);
                    end
                end
                pay_idx = p + 1;
                if (pay_idx == flen) begin
                    stage   = PH_HEADER;
                    hdr_idx = 0;
                    if (!hit)
                        hit = frame_end(r);
                end
            end
            default: ;
        endcase
        return hit;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stage    = PH_PREFACE;
            pre_idx  = 0;
            pre_ok   = 1'b1;
            hdr_idx  = 0;
            flen     = '0;
            ftype    = '0;
            fflags   = '0;
            fstream  = '0;
            pay_idx  = '0;
            blk_lo   = '0;
            blk_hi   = '0;
            max_len  = MAX_FRAME_RESET;
            o_errors = 0;
            expected_results.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: kind %0d data %0h stream %0h last %0b",
                           res_ch.kind, res_ch.data, res_ch.stream_no, res_ch.last);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (res_ch.kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, got %0d", want.kind, res_ch.kind);
                        o_errors++;
                    end
                    if (res_ch.data !== want.data) begin
                        $error("data mismatch: expected %0h, got %0h", want.data, res_ch.data);
                        o_errors++;
                    end
                    if (res_ch.stream_no !== want.stream_no) begin
                        $error("stream_no mismatch: expected %0h, got %0h",
                               want.stream_no, res_ch.stream_no);
                        o_errors++;
                    end
                    if (res_ch.last !== want.last) begin
                        $error("last mismatch: expected %0b, got %0b", want.last, res_ch.last);
                        o_errors++;
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
                max_len = cfg_ch.max_frame_size;
            if (conn_ch.valid && conn_ch.ready) begin
                if (deframe_byte(conn_ch.in_byte, predicted))
                    expected_results.push_back(predicted);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: verif/testbench.sv
module testbench;
    import h2d_pkg::*;

    localparam logic [8*24-1:0] CONN_PREFACE =
        "PRI * HTTP/2.0\015\012\015\012SM\015\012\015\012";
    localparam logic [7:0] TYPE_DATA   = 8'h00;
    localparam logic [7:0] F_NONE      = 8'h00;
    localparam logic [7:0] F_ACK       = 8'(1 << FLAG_ACK_BIT);
    localparam logic [7:0] F_PADDED    = 8'(1 << FLAG_PADDED_BIT);
    localparam logic [7:0] F_PRIO      = 8'(1 << FLAG_PRIO_BIT);
    localparam logic [7:0] F_END_HDRS  = 8'h04;
    localparam int         HOLD_CYCLES = 300;
    localparam int         STALL_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;

    h2d_in_if  conn_ch ();
    h2d_out_if res_ch ();
    h2d_cfg_if cfg_ch ();

    int          chk_errors;
    int          chk_pending;
    int          idle_cycles;
    int unsigned sent_bytes;
    bit          tx_calm;
    bit          rx_calm;
    bit          rx_hold;

    http2_frame_deframer i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (conn_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    h2d_deframe_checker #(.PREFACE(CONN_PREFACE)) i_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .conn_ch   (conn_ch),
        .cfg_ch    (cfg_ch),
        .res_ch    (res_ch),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // no beat on any channel for too long means the block is stuck
    always @(posedge i_clk) begin
        if ((conn_ch.valid && conn_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : result_sink
        int unsigned gap;
        bit          hold_done;
        res_ch.ready = 1'b0;
        hold_done    = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 63) == 0)
                rx_calm = !rx_calm;
            if (rx_hold && !hold_done) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            gap = rx_calm ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if ($urandom_range(0, 63) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            conn_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        conn_ch.valid   <= 1'b1;
        conn_ch.in_byte <= b;
        do @(posedge i_clk); while (!(conn_ch.valid && conn_ch.ready));
        sent_bytes++;
    endtask

    task automatic send_header(input logic [23:0] len, input logic [7:0] ftype,
                               input logic [7:0] flags, input logic [31:0] sid);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        send_byte(ftype);
        send_byte(flags);
        send_byte(sid[31:24]);
        send_byte(sid[23:16]);
        send_byte(sid[15:8]);
        send_byte(sid[7:0]);
    endtask

    task automatic send_frame(input logic [23:0] len, input logic [7:0] ftype,
                              input logic [7:0] flags, input logic [31:0] sid,
                              input logic [7:0] pad);
        int unsigned i;
        send_header(len, ftype, flags, sid);
        for (i = 0; i < len; i++) begin
            if (i == 0 && ftype == TYPE_HEADERS && flags[FLAG_PADDED_BIT])
                send_byte(pad);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_random_frame(input int unsigned cap);
        int unsigned len;
        int unsigned sel;
        logic [7:0]  ftype;
        logic [7:0]  pad;
        logic [31:0] sid;
        if ($urandom_range(0, 9) == 0)
            len = $urandom_range(0, cap);
        else
            len = $urandom_range(0, cap < 20 ? cap : 20);
        sel = $urandom_range(0, 9);
        if (sel < 6)
            ftype = TYPE_HEADERS;
        else if (sel < 8)
            ftype = TYPE_SETTINGS;
        else
            ftype = 8'($urandom_range(0, 255));
        sid = $urandom();
        if ($urandom_range(0, 9) == 0)
            sid[30:0] = '0;
        // mostly padding that fits, sometimes too much
        if (len > 0 && $urandom_range(0, 3) != 0)
            pad = 8'($urandom_range(0, len - 1 > 255 ? 255 : len - 1));
        else
            pad = 8'($urandom_range(0, 255));
        send_frame(24'(len), ftype, 8'($urandom_range(0, 255)), sid, pad);
    endtask

    // stop offering bytes until every result is out, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        conn_ch.valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_max(input logic [LEN_W-1:0] v);
        @(negedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.max_frame_size <= v;
        do @(posedge i_clk); while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned      i;
        bit               held;
        logic [LEN_W-1:0] mid_max;
        i_rst_n               = 1'b0;
        conn_ch.valid         = 1'b0;
        conn_ch.in_byte       = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.max_frame_size = '0;
        sent_bytes            = 0;
        tx_calm               = 1'b0;
        held                  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_max(24'hFFFFFF);
        for (i = 0; i < 24; i++)
            send_byte(CONN_PREFACE[8*(23-i) +: 8]);

        // directed frames
        send_frame(3, TYPE_HEADERS, F_END_HDRS, 32'h8000_0001, 8'h00);
        send_frame(0, TYPE_HEADERS, F_NONE, 32'd5, 8'h00);
        send_frame(0, TYPE_SETTINGS, F_NONE, 32'd0, 8'h00);
        send_frame(6, TYPE_SETTINGS, F_ACK, 32'd0, 8'h00);
        send_frame(4, TYPE_HEADERS, F_PADDED, 32'd7, 8'd2);
        send_frame(3, TYPE_HEADERS, F_PADDED, 32'd9, 8'd9);
        send_frame(5, TYPE_HEADERS, F_PRIO, 32'd11, 8'h00);
        send_frame(4, TYPE_HEADERS, F_PRIO, 32'd13, 8'h00);
        send_frame(8, TYPE_HEADERS, F_PADDED | F_PRIO, 32'h7FFF_FFFF, 8'd1);
        send_frame(1, TYPE_HEADERS, F_PADDED, 32'd15, 8'd0);
        send_frame(2, TYPE_HEADERS, F_NONE, 32'h8000_0000, 8'h00);
        send_frame(2, TYPE_DATA, 8'hFF, 32'hFFFF_FFFF, 8'h00);
        send_frame(1, TYPE_SETTINGS, F_NONE, 32'd3, 8'h00);
        drain();

        // largest limit, with one long output stall
        while (sent_bytes < 700) begin
            if (!held && sent_bytes > 300) begin
                held    = 1'b1;
                rx_hold = 1'b1;
                send_frame(60, TYPE_HEADERS, F_NONE, {1'b0, 31'($urandom()) | 31'd1}, 8'h00);
            end else begin
                send_random_frame(48);
            end
        end
        drain();

        // zero limit: only empty frames pass
        write_max('0);
        for (i = 0; i < 40; i++)
            send_random_frame(0);
        drain();

        mid_max = LEN_W'($urandom_range(1, 40));
        write_max(mid_max);
        send_frame(mid_max, TYPE_HEADERS, F_NONE, 32'd21, 8'h00);
        while (sent_bytes < 1350)
            send_random_frame(mid_max);
        drain();

        // back to the reset limit, then a frame over it kills the block
        write_max(MAX_FRAME_RESET);
        for (i = 0; i < 8; i++)
            send_random_frame(20);
        send_header(24'hFFFFFF, TYPE_HEADERS, F_NONE, $urandom());
        for (i = 0; i < 20; i++)
            send_byte(8'($urandom_range(0, 255)));
        drain();
        repeat (10) @(negedge i_clk);

        if (chk_errors == 0 && chk_pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: http2_frame_deframer.f
rtl/h2d_pkg.sv
rtl/h2d_if.sv
rtl/h2d_parser.sv
rtl/h2d_out_reg.sv
rtl/http2_frame_deframer.sv
verif/h2d_deframe_checker.sv
verif/testbench.sv
